### hdl/enms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_pkg: shared types and constants for edge non-maximum suppression
// Field widths, angle bounds, direction codes, register indexes and the
// structs that pass between the control, window and line buffer modules.
// ----------------------------------------------------------------------------
package enms_pkg;

  // Field and counter widths
  localparam int MAG_W     = 16;
  localparam int ANG_W     = 13;
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int ROW_W     = 16;
  localparam int SEC_W     = 2;
  localparam int FOLD_W    = ANG_W + 1;

  // Clamp bounds and reset values for the frame size registers
  localparam logic [WID_W-1:0] MIN_WIDTH_C  = WID_W'(3);
  localparam logic [WID_W-1:0] MAX_WIDTH_C  = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] MIN_HEIGHT_C = ROW_W'(3);
  localparam logic [WID_W-1:0] RST_WIDTH    = WID_W'(640);
  localparam logic [ROW_W-1:0] RST_HEIGHT   = ROW_W'(480);

  // Angle bounds in 1/16 degree
  localparam logic signed [FOLD_W-1:0] DEG_180 = FOLD_W'(2880);
  localparam logic signed [FOLD_W-1:0] DEG_360 = FOLD_W'(5760);
  localparam logic signed [FOLD_W-1:0] NEG_180 = -FOLD_W'(2880);
  localparam logic signed [FOLD_W-1:0] TH_22   = FOLD_W'(360);
  localparam logic signed [FOLD_W-1:0] TH_67   = FOLD_W'(1080);
  localparam logic signed [FOLD_W-1:0] TH_112  = FOLD_W'(1800);
  localparam logic signed [FOLD_W-1:0] TH_157  = FOLD_W'(2520);

  // Gradient direction codes
  localparam logic [SEC_W-1:0] SEC_HORZ = 2'd0;
  localparam logic [SEC_W-1:0] SEC_D45  = 2'd1;
  localparam logic [SEC_W-1:0] SEC_VERT = 2'd2;
  localparam logic [SEC_W-1:0] SEC_D135 = 2'd3;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One line buffer entry: two magnitude rows and the direction of the middle row
  typedef struct packed {
    logic [MAG_W-1:0] upper;
    logic [MAG_W-1:0] middle;
    logic [SEC_W-1:0] sector;
  } line_word_t;

  // Item handed from the control stage to the window stage
  typedef struct packed {
    logic             pix;
    logic             emit;
    logic             interior;
    logic             last;
    logic [SEC_W-1:0] sector;
    logic [MAG_W-1:0] mag;
    logic [COL_W-1:0] addr;
  } item_t;

endpackage

### hdl/enms_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_line_ram: line buffer memory
// One write port and one read port, registered read data.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module enms_line_ram import enms_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  line_word_t       wr_data_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output line_word_t       rd_data_o
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/enms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_ctrl: frame sequencing and angle quantization
// Holds the frame size registers and the column, row and drain counters,
// classifies each accepted item and issues the line buffer read.
// ----------------------------------------------------------------------------
module enms_ctrl import enms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [ANG_W-1:0] angle_i,
  input  logic             flush_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [ROW_W-1:0] cfg_data_i,
  output item_t            item_o,
  output logic             load_o,
  output logic             rd_en_o,
  output logic [COL_W-1:0] rd_addr_o,
  output logic             restart_o
);

  logic [WID_W-1:0] width_q, width_d;
  logic [ROW_W-1:0] height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WID_W-1:0] drn_q, drn_d;

  logic [WID_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [WID_W-1:0] col_inc;
  logic             col_wrap;
  logic             drain;
  logic             drain_last;
  logic             cfg_hit;

  logic signed [FOLD_W-1:0] ang_ext;
  logic signed [FOLD_W-1:0] ang_fold;
  logic [SEC_W-1:0]         sector;

  // Clamp the frame size
  always_comb begin
    w_eff = width_q;
    if (width_q < MIN_WIDTH_C) begin
      w_eff = MIN_WIDTH_C;
    end else if (width_q > MAX_WIDTH_C) begin
      w_eff = MAX_WIDTH_C;
    end
    h_eff = (height_q < MIN_HEIGHT_C) ? MIN_HEIGHT_C : height_q;
  end

  // Fold the angle into 0..180 degrees and pick the direction
  always_comb begin
    ang_ext = FOLD_W'(signed'(angle_i));
    if (ang_ext < NEG_180) begin
      ang_fold = ang_ext + DEG_360;
    end else if (ang_ext < 0) begin
      ang_fold = ang_ext + DEG_180;
    end else if (ang_ext > DEG_180) begin
      ang_fold = ang_ext - DEG_180;
    end else begin
      ang_fold = ang_ext;
    end
    if (ang_fold < TH_22 || ang_fold >= TH_157) begin
      sector = SEC_HORZ;
    end else if (ang_fold < TH_67) begin
      sector = SEC_D45;
    end else if (ang_fold < TH_112) begin
      sector = SEC_VERT;
    end else begin
      sector = SEC_D135;
    end
  end

  // Classify the item at the head of the input
  assign drain      = (row_q >= h_eff);
  assign drain_last = drain && (drn_q == w_eff);
  assign col_inc    = WID_W'(col_q) + WID_W'(1);
  assign col_wrap   = (col_inc == w_eff);

  always_comb begin
    item_o.pix      = !drain;
    item_o.emit     = drain || ((row_q != '0) && !((row_q == ROW_W'(1)) && (col_q == '0)));
    item_o.interior = !drain && (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    item_o.last     = drain_last;
    item_o.sector   = sector;
    item_o.mag      = mag_i;
    item_o.addr     = col_q;
  end

  assign load_o    = fire_i && (drain || !flush_i);
  assign rd_en_o   = fire_i && !drain && !flush_i;
  assign rd_addr_o = col_q;

  // Register writes restart the frame
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH: begin
          width_d = cfg_data_i[WID_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = cfg_data_i;
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign restart_o = cfg_hit || (fire_i && drain_last);

  // Advance the counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    drn_d = drn_q;
    if (restart_o) begin
      col_d = '0;
      row_d = '0;
      drn_d = '0;
    end else if (fire_i && drain) begin
      drn_d = drn_q + WID_W'(1);
    end else if (fire_i && !flush_i) begin
      col_d = col_wrap ? '0 : col_inc[COL_W-1:0];
      row_d = col_wrap ? row_q + ROW_W'(1) : row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
      drn_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      drn_q    <= drn_d;
    end
  end

endmodule

### hdl/enms_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_window: 3x3 window, suppression compare and output register
// Takes the registered line buffer read data, shifts the window,
// writes the line buffer entry back and registers the result item.
// ----------------------------------------------------------------------------
module enms_window import enms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             load_i,
  input  logic             restart_i,
  input  line_word_t       rd_data_i,
  output logic             ready_o,
  output logic             wr_en_o,
  output logic [COL_W-1:0] wr_addr_o,
  output line_word_t       wr_data_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [MAG_W-1:0] m_data_o,
  output logic             m_last_o
);

  logic             s1_vld_q, s1_vld_d;
  item_t            s1_q;
  logic [MAG_W-1:0] win_q [9];
  logic [MAG_W-1:0] win_nxt [9];
  logic [SEC_W-1:0] held_q;
  logic             out_vld_q, out_vld_d;
  logic [MAG_W-1:0] out_mag_q;
  logic             out_last_q;

  logic             s1_adv;
  logic [MAG_W-1:0] ctr, e1, e2, res;

  // Stage advances when it emits nothing or its result has a free output slot
  assign s1_adv  = s1_vld_q && (!s1_q.emit || !out_vld_q || m_ready_i);
  assign ready_o = !s1_vld_q || s1_adv;

  // Shifted window with the new column on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]   = win_q[k*3+1];
      win_nxt[k*3+1] = win_q[k*3+2];
    end
    win_nxt[2] = rd_data_i.upper;
    win_nxt[5] = rd_data_i.middle;
    win_nxt[8] = s1_q.mag;
  end

  // Pick the neighbours along the gradient and compare
  always_comb begin
    ctr = win_nxt[4];
    case (held_q)
      SEC_HORZ: begin
        e1 = win_nxt[5];
        e2 = win_nxt[3];
      end
      SEC_D45: begin
        e1 = win_nxt[6];
        e2 = win_nxt[2];
      end
      SEC_VERT: begin
        e1 = win_nxt[7];
        e2 = win_nxt[1];
      end
      default: begin
        e1 = win_nxt[0];
        e2 = win_nxt[8];
      end
    endcase
    res = (s1_q.interior && (ctr >= e1) && (ctr >= e2)) ? ctr : '0;
  end

  // Write the entry back: middle row moves up, new pixel becomes middle
  assign wr_en_o          = s1_adv && s1_q.pix;
  assign wr_addr_o        = s1_q.addr;
  assign wr_data_o.upper  = rd_data_i.middle;
  assign wr_data_o.middle = s1_q.mag;
  assign wr_data_o.sector = s1_q.sector;

  // Stage one occupancy
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (load_i) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  // Output slot occupancy
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv && s1_q.emit) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the stage payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
  end

  // Shift the window and hold the centre column direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      held_q <= SEC_HORZ;
    end else if (restart_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      held_q <= SEC_HORZ;
    end else if (s1_adv && s1_q.pix) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_nxt[i];
      end
      held_q <= rd_data_i.sector;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      out_mag_q  <= res;
      out_last_q <= s1_q.last;
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_mag_q;
  assign m_last_o  = out_last_q;

endmodule

### hdl/edge_nonmax_suppress_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_nonmax_suppress_3x3_core: Canny non-maximum suppression, 3x3 window
// Raster stream of gradient magnitude and angle in, suppressed magnitude out.
//
//   Port group  Dir  Payload
//   s_axis      in   tdata: magnitude[15:0], angle[28:16], zero[31:29];
//                    tuser: flush
//   m_axis      out  tdata: kept_magnitude[15:0]; tlast: frame_end
//   cfg         in   index 0 = image_width, 1 = image_height
//
// One item per clock unless the output stalls; the line buffer read lands
// at the accepting edge and the result is registered as the stage advances.
// Results trail the pixels by image_width+1 items; flush items drain them.
// The line buffer is one 1024 x 34 memory, one read and one write per cycle.
// Reset clears counters, window and handshake state; the line buffer needs
// no clearing pass and is accepted from the first cycle.
// A stalled output holds the window stage, and the input then stalls too.
// ----------------------------------------------------------------------------
module edge_nonmax_suppress_3x3_core import enms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,  // magnitude[15:0], angle[28:16], zero
  input  logic             s_axis_tuser_i,  // flush
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [MAG_W-1:0] m_axis_tdata_o,  // kept_magnitude[15:0]
  output logic             m_axis_tlast_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [ROW_W-1:0] cfg_data_i
);

  item_t            item;
  logic             load;
  logic             restart;
  logic             s_fire;
  logic             ram_re;
  logic [COL_W-1:0] ram_raddr;
  line_word_t       ram_rdata;
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  line_word_t       ram_wdata;

  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  // Frame sequencing
  enms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s_fire),
    .mag_i       (s_axis_tdata_i[MAG_W-1:0]),
    .angle_i     (s_axis_tdata_i[MAG_W+ANG_W-1:MAG_W]),
    .flush_i     (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_o      (item),
    .load_o      (load),
    .rd_en_o     (ram_re),
    .rd_addr_o   (ram_raddr),
    .restart_o   (restart)
  );

  // Line buffer
  enms_line_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Window, compare and output
  enms_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .load_i    (load),
    .restart_i (restart),
    .rd_data_i (ram_rdata),
    .ready_o   (s_axis_tready_o),
    .wr_en_o   (ram_we),
    .wr_addr_o (ram_waddr),
    .wr_data_o (ram_wdata),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

  // The closing result of a frame is a border pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o == '0)
    else $error("frame end result carries a nonzero magnitude");

  // Write-back and the next read never hit the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("line buffer read and write collide");

  // A line buffer read only happens when the window stage takes the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> load && s_axis_tready_o)
    else $error("line buffer read without a stage load");

endmodule
